>>> rtl/core/tap_tempo_estimator_top_assert.svh
// assertion macros for the tap tempo estimator checker
// each macro expands to one labeled concurrent assertion on clock, muted in reset
`ifndef TAP_TEMPO_ESTIMATOR_TOP_ASSERT_SVH
`define TAP_TEMPO_ESTIMATOR_TOP_ASSERT_SVH

// same-cycle implication
`define TTE_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("tap tempo check failed");

// next-cycle implication
`define TTE_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tap tempo check failed");

`endif

>>> rtl/core/tte_pkg.sv
// shared constants, types and helper functions of the tap tempo estimator
// no dependencies; imported by the divider, the top level and the checker
`default_nettype none

package tte_pkg;

   localparam int HISTORY    = 8;
   localparam int TIME_W     = 48;
   localparam int TIMEOUT_W  = 32;
   localparam int CENTI_W    = 17;
   localparam int COUNT_W    = 3;
   localparam int SLOT_W     = $clog2(HISTORY);
   localparam int HELD_W     = $clog2(HISTORY + 1);
   localparam int NUM_W      = TIME_W + 1;
   localparam int ITER_W     = $clog2(NUM_W);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // twice the number of centi-beats-minute microseconds: 2 * 6e9
   localparam logic [NUM_W-1:0] TWO_CENTI_MINUTE = NUM_W'(64'd12000000000);

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(2000000);
   localparam logic [CENTI_W-1:0]   MIN_RESET     = CENTI_W'(2000);
   localparam logic [CENTI_W-1:0]   MAX_RESET     = CENTI_W'(99900);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIMEOUT   = 2'd0,
      CSR_MIN_TEMPO = 2'd1,
      CSR_MAX_TEMPO = 2'd2
   } csr_index_type;

   // divider status seen by the sequencer
   typedef struct packed {
      logic done;
      logic sat;
   } div_status_type;

   // numerator scale: 2 * 6e9 * n
   function automatic logic [NUM_W-1:0] scaled_minute(input logic [SLOT_W-1:0] n);
      logic [NUM_W+SLOT_W-1:0] prod;
      prod = {{SLOT_W{1'b0}}, TWO_CENTI_MINUTE} * {{NUM_W{1'b0}}, n};
      return prod[NUM_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/tte_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module tte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/tte_div.sv
// restoring divider, one quotient bit per cycle, flags quotient overflow
// depends on tte_pkg
`default_nettype none

module tte_div
   import tte_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [NUM_W-1:0]   num,
   input  wire logic [NUM_W-1:0]   den,
   output logic      [CENTI_W-1:0] quot,
   output div_status_type          status
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [ITER_W-1:0]  count_ff, count_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [NUM_W-1:0]   den_ff, den_in;
   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic [CENTI_W-1:0] quot_ff, quot_in;
   logic               sat_ff, sat_in;

   logic [NUM_W:0]     shifted;
   logic [NUM_W+1:0]   trial;
   logic               fits;

   // bring down the next numerator bit and try the subtract
   assign shifted = {rem_ff, num_ff[NUM_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};
   assign fits    = !trial[NUM_W+1];

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      sat_in   = sat_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = ITER_W'(NUM_W - 1);
         num_in   = num;
         den_in   = den;
         rem_in   = '0;
         quot_in  = '0;
         sat_in   = 1'b0;
      end else if (busy_ff) begin
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         rem_in  = fits ? trial[NUM_W-1:0] : shifted[NUM_W-1:0];
         // a set top bit shifted out means the quotient left the range
         sat_in  = sat_ff | quot_ff[CENTI_W-1];
         quot_in = {quot_ff[CENTI_W-2:0], fits};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - ITER_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      sat_ff   <= sat_in;
   end

   assign quot        = quot_ff;
   assign status.done = done_ff;
   assign status.sat  = sat_ff;

endmodule

`default_nettype wire

>>> rtl/core/tap_tempo_estimator_top.sv
// tap tempo estimator: timestamps in, tempo in hundredths of bpm out
// the tempo is formed by the bit-serial divider (one quotient bit per cycle over 49 bits);
//   an equal or backward span skips the divider, and a tap with no tempo returns to idle
// taps are taken one at a time; the result register lets the next tap in while a tempo
//   waits to be taken
// reset: synchronous, active high; history emptied, limits and timeout to defaults
`default_nettype none

module tap_tempo_estimator_top
   import tte_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // tap transactions
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [TIME_W-1:0]     req_tap_time_us,
   // tempo transactions
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [CENTI_W-1:0]    rsp_tempo_centi,
   output logic      [COUNT_W-1:0]    rsp_interval_count,
   // register writes
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // one-hot sequencer
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,  // waiting for a tap
      ST_CHECK = 6'b000010,  // timeout test, ring write, oldest-tap read
      ST_READ  = 6'b000100,  // oldest tap arrives, span formed
      ST_SETUP = 6'b001000,  // numerator built, divider started
      ST_DIV   = 6'b010000,  // divider iterating
      ST_DONE  = 6'b100000   // clamp and hand to the result register
   } state_type;

   localparam int SUM_W = SLOT_W + 2;

   state_type          state_ff, state_in;

   // configuration
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [CENTI_W-1:0]   min_ff, min_in;
   logic [CENTI_W-1:0]   max_ff, max_in;

   // tap history bookkeeping
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [TIME_W-1:0]  last_ff, last_in;
   logic [SLOT_W-1:0]  ws_ff, ws_in;
   logic [HELD_W-1:0]  held_ff, held_in;
   logic [SLOT_W-1:0]  n_ff, n_in;
   logic [NUM_W-1:0]   scale_ff, scale_in;
   logic [TIME_W-1:0]  span_ff, span_in;
   logic               force_max_ff, force_max_in;
   logic               force_zero_ff, force_zero_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CENTI_W-1:0] rsp_tempo_ff, rsp_tempo_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // combinational helpers
   logic [TIME_W-1:0]  gap;
   logic               timed_out;
   logic [HELD_W-1:0]  held_kept;
   logic [HELD_W-1:0]  held_new;
   logic [HELD_W-1:0]  held_minus;
   logic [SUM_W-1:0]   old_sum;
   logic [SUM_W-1:0]   old_wrap;
   logic [SLOT_W-1:0]  old_addr;
   logic [SLOT_W-1:0]  ws_next;
   logic [TIME_W-1:0]  oldest_tap;

   logic               ram_wr_en;
   logic               div_start;
   logic [NUM_W-1:0]   div_num;
   logic [NUM_W-1:0]   div_den;
   logic [CENTI_W-1:0] div_quot;
   div_status_type     div_status;

   logic [CENTI_W-1:0] q_val;
   logic               q_sat;
   logic [CENTI_W-1:0] lowered;
   logic [CENTI_W-1:0] tempo;
   logic               out_free;

   // timestamp ring, one entry per kept tap
   tte_ram #(
      .WIDTH (TIME_W),
      .DEPTH (HISTORY)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ws_ff),
      .wr_data (now_ff),
      .rd_addr (old_addr),
      .rd_data (oldest_tap)
   );

   // bit-serial divider for round(6e9 * n / span)
   tte_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .quot   (div_quot),
      .status (div_status)
   );

   // gap test: only a forward step longer than the timeout forgets history
   assign gap       = now_ff - last_ff;
   assign timed_out = (held_ff != '0) && (now_ff >= last_ff) &&
                      (gap > {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_ff});
   assign held_kept = timed_out ? '0 : held_ff;
   assign held_new  = (held_kept < HELD_W'(HISTORY)) ? held_kept + HELD_W'(1) : held_kept;
   assign held_minus = held_new - HELD_W'(1);

   // oldest kept tap sits held_new - 1 slots behind the one written now
   assign old_sum  = SUM_W'(ws_ff) + SUM_W'(HISTORY + 1) - SUM_W'(held_new);
   assign old_wrap = (old_sum >= SUM_W'(HISTORY)) ? old_sum - SUM_W'(HISTORY) : old_sum;
   assign old_addr = old_wrap[SLOT_W-1:0];
   assign ws_next  = (ws_ff == SLOT_W'(HISTORY - 1)) ? '0 : ws_ff + SLOT_W'(1);

   assign ram_wr_en = (state_ff == ST_CHECK);

   // numerator carries half the divisor so the quotient rounds half up
   assign div_num   = scale_ff + {1'b0, span_ff};
   assign div_den   = {span_ff, 1'b0};
   assign div_start = (state_ff == ST_SETUP) && !force_max_ff && !force_zero_ff;

   // clamp: minimum first, then maximum, so the maximum wins when limits cross
   assign q_val   = force_zero_ff ? '0 : div_quot;
   assign q_sat   = force_max_ff | (!force_zero_ff & div_status.sat);
   assign lowered = (!q_sat && (q_val < min_ff)) ? min_ff : q_val;
   assign tempo   = (q_sat || (lowered > max_ff)) ? max_ff : lowered;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      timeout_in    = timeout_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      now_in        = now_ff;
      last_in       = last_ff;
      ws_in         = ws_ff;
      held_in       = held_ff;
      n_in          = n_ff;
      scale_in      = scale_ff;
      span_in       = span_ff;
      force_max_in  = force_max_ff;
      force_zero_in = force_zero_ff;
      rsp_tempo_in  = rsp_tempo_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      // register writes land whenever offered
      if (csr_wr_en) begin
         case (csr_index)
            CSR_TIMEOUT:   timeout_in = csr_wdata[TIMEOUT_W-1:0];
            CSR_MIN_TEMPO: min_in     = csr_wdata[CENTI_W-1:0];
            CSR_MAX_TEMPO: max_in     = csr_wdata[CENTI_W-1:0];
            default:       ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in   = req_tap_time_us;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // ring write happens this cycle; oldest read is registered in the ram
            held_in  = held_new;
            ws_in    = ws_next;
            last_in  = now_ff;
            n_in     = held_minus[SLOT_W-1:0];
            scale_in = scaled_minute(held_minus[SLOT_W-1:0]);
            state_in = (held_new >= HELD_W'(2)) ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            span_in       = now_ff - oldest_tap;
            force_max_in  = (now_ff == oldest_tap);
            force_zero_in = (now_ff < oldest_tap);
            state_in      = ST_SETUP;
         end
         ST_SETUP: begin
            // equal or backward spans skip the divider
            state_in = (force_max_ff || force_zero_ff) ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_tempo_in = tempo;
               rsp_count_in = COUNT_W'(n_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         timeout_ff   <= TIMEOUT_RESET;
         min_ff       <= MIN_RESET;
         max_ff       <= MAX_RESET;
         ws_ff        <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timeout_ff   <= timeout_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         ws_ff        <= ws_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff        <= now_in;
      last_ff       <= last_in;
      n_ff          <= n_in;
      scale_ff      <= scale_in;
      span_ff       <= span_in;
      force_max_ff  <= force_max_in;
      force_zero_ff <= force_zero_in;
      rsp_tempo_ff  <= rsp_tempo_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tempo_centi    = rsp_tempo_ff;
   assign rsp_interval_count = rsp_count_ff;

endmodule

`default_nettype wire

>>> rtl/core/tte_chk.sv
// port-level checker for the tap tempo estimator, bound to the top level
// depends on tte_pkg and tap_tempo_estimator_top_assert.svh
`default_nettype none

`include "tap_tempo_estimator_top_assert.svh"

module tte_chk
   import tte_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [CENTI_W-1:0]    rsp_tempo_centi,
   input wire logic [COUNT_W-1:0]    rsp_interval_count
);

   // a stalled tempo stays offered and holds its value
   `TTE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `TTE_ASSERT_NEXT(a_tempo_stable, rsp_valid && !rsp_ready, $stable(rsp_tempo_centi))
   `TTE_ASSERT_NEXT(a_count_stable, rsp_valid && !rsp_ready, $stable(rsp_interval_count))

   // one tap at a time: busy right after a tap transaction
   `TTE_ASSERT_NEXT(a_busy_after_tap, req_valid && req_ready, !req_ready)

   // a new tempo only comes out of a cycle in which the block was busy
   `TTE_ASSERT_NOW(a_tempo_from_work, $rose(rsp_valid), !$past(req_ready))

endmodule

bind tap_tempo_estimator_top tte_chk u_tte_chk (.*);

`default_nettype wire
